/* src/ssr_pkg.sv */
`default_nettype none

package ssr_pkg;

    localparam int PATTERN_MAX     = 8;
    localparam int REPLACEMENT_MAX = 8;
    // most results one text byte can cause
    localparam int MAX_RES         = (PATTERN_MAX > REPLACEMENT_MAX) ? PATTERN_MAX
                                                                      : REPLACEMENT_MAX;
    // one spare slot lets a new byte in while a result still waits
    localparam int QDEPTH          = MAX_RES + 1;

    localparam int CNT_W     = $clog2(MAX_RES + 1);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);
    localparam int LEN_W     = 4;
    localparam int CFG_W     = 64;
    localparam int REG_NUM   = 4;
    localparam int REG_IDX_W = $clog2(REG_NUM);
    localparam int ADDR_W    = REG_IDX_W + 3;

    typedef logic [7:0] byte_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PATTERN_LEN   = 2'd0,
        REG_PATTERN_BYTES = 2'd1,
        REG_REPL_LEN      = 2'd2,
        REG_REPL_BYTES    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        byte_t data;
        logic  has;
        logic  last;
    } res_t;

    typedef struct packed {
        logic write;
        logic insert;
        logic shift;
    } win_ctl_t;

    typedef struct packed {
        logic load;
        logic shift;
    } out_ctl_t;

    // zero means one, anything above the window size saturates
    function automatic logic [CNT_W-1:0] eff_plen(input logic [LEN_W-1:0] v);
        logic [CNT_W-1:0] n;
        if (v == '0)
            n = CNT_W'(1);
        else if (int'(v) > PATTERN_MAX)
            n = CNT_W'(PATTERN_MAX);
        else
            n = CNT_W'(v);
        return n;
    endfunction

    function automatic logic [CNT_W-1:0] eff_rlen(input logic [LEN_W-1:0] v);
        logic [CNT_W-1:0] n;
        if (int'(v) > REPLACEMENT_MAX)
            n = CNT_W'(REPLACEMENT_MAX);
        else
            n = CNT_W'(v);
        return n;
    endfunction

endpackage

`default_nettype wire

/* src/ssr_win_cell.sv */
`default_nettype none

module ssr_win_cell (
    input  wire logic              clk,
    input  wire ssr_pkg::win_ctl_t ctl,
    input  wire ssr_pkg::byte_t    in_byte,
    input  wire ssr_pkg::byte_t    neigh,
    input  wire ssr_pkg::byte_t    pat_byte,
    output ssr_pkg::byte_t         wnew,
    output logic                   eq
);
    import ssr_pkg::*;

    byte_t data_reg;
    byte_t data_next;

    // window byte with the incoming text byte placed in this slot
    assign wnew = ctl.insert ? in_byte : data_reg;
    assign eq   = (wnew == pat_byte);

    assign data_next = ctl.shift ? neigh : wnew;

    always_ff @(posedge clk)
    begin
        if (ctl.write)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* src/ssr_out_cell.sv */
`default_nettype none

module ssr_out_cell (
    input  wire logic              clk,
    input  wire ssr_pkg::out_ctl_t ctl,
    input  wire ssr_pkg::res_t     load_val,
    input  wire ssr_pkg::res_t     neigh,
    output ssr_pkg::res_t          q
);
    import ssr_pkg::*;

    res_t q_reg;
    res_t q_next;

    always_comb
    begin
        priority if (ctl.load)
            q_next = load_val;
        else if (ctl.shift)
            q_next = neigh;
        else
            q_next = q_reg;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

/* src/stream_substring_replace.sv */
// the results of a byte are registered into the output queue as the byte is taken
// throughput: one text byte per cycle with m_tready high and each yields at most one
//   result; a byte with n results holds s_tready low until the queue drains to one
// the output queue of cells shifts one result per cycle, which bounds the output rate
// reset: rst_n is asynchronous, active low; clears window and queue counts and loads
//   pattern_length 1, other registers 0; no clearing pass, ready right after reset
`default_nettype none

module stream_substring_replace (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ssr_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [ssr_pkg::CFG_W-1:0]   pwdata,
    output logic      [ssr_pkg::CFG_W-1:0]   prdata,
    output logic                             pready,
    // text in
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // text_byte
    input  wire logic                        s_tlast,   // text_last
    // edited text out
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [7:0]                  m_tdata,   // out_byte
    output logic                             m_tuser,   // out_has_byte
    output logic                             m_tlast    // out_last
);
    import ssr_pkg::*;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [LEN_W-1:0] plen_reg, plen_next;
    logic [CFG_W-1:0] pat_reg, pat_next;
    logic [LEN_W-1:0] rlen_reg, rlen_next;
    logic [CFG_W-1:0] rep_reg, rep_next;

    logic     cfg_wr;
    reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1 -: REG_IDX_W]);

    always_comb
    begin
        plen_next = plen_reg;
        pat_next  = pat_reg;
        rlen_next = rlen_reg;
        rep_next  = rep_reg;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_PATTERN_LEN:   plen_next = pwdata[LEN_W-1:0];
                REG_PATTERN_BYTES: pat_next  = pwdata;
                REG_REPL_LEN:      rlen_next = pwdata[LEN_W-1:0];
                REG_REPL_BYTES:    rep_next  = pwdata;
                default:           ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (cfg_idx)
            REG_PATTERN_LEN:   prdata = CFG_W'(plen_reg);
            REG_PATTERN_BYTES: prdata = pat_reg;
            REG_REPL_LEN:      prdata = CFG_W'(rlen_reg);
            REG_REPL_BYTES:    prdata = rep_reg;
            default:           prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // lookahead window: a row of byte cells, oldest byte in cell 0
    // ---------------------------------------------------------------
    logic [CNT_W-1:0]  plen, rlen;
    logic [CNT_W-1:0]  wcnt_reg, wcnt_next;
    logic [CNT_W-1:0]  cnt_in, cnt_inc;
    logic              accept, full, match, shift;
    byte_t             wnew [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] eq, eq_masked;

    assign plen    = eff_plen(plen_reg);
    assign rlen    = eff_rlen(rlen_reg);
    assign accept  = s_tvalid & s_tready;

    // a window already at pattern size (never after a length write) restarts empty
    assign cnt_in  = (wcnt_reg >= plen) ? '0 : wcnt_reg;
    assign cnt_inc = cnt_in + CNT_W'(1);
    assign full    = (cnt_inc == plen);
    assign match   = full & (&eq_masked);
    // mismatch on a full window drops the oldest byte, unless the string ends here
    assign shift   = full & ~match & ~s_tlast;

    for (genvar i = 0; i < PATTERN_MAX; i++)
    begin : g_win
        win_ctl_t wctl;

        assign wctl.write  = accept;
        assign wctl.insert = (cnt_in == CNT_W'(i));
        assign wctl.shift  = shift;
        // slots beyond the pattern length always compare true
        assign eq_masked[i] = eq[i] | (CNT_W'(i) >= plen);

        ssr_win_cell u_cell (
            .clk      (clk),
            .ctl      (wctl),
            .in_byte  (s_tdata),
            .neigh    ((i < PATTERN_MAX - 1) ? wnew[(i + 1) % PATTERN_MAX] : wnew[i]),
            .pat_byte (pat_reg[8*i +: 8]),
            .wnew     (wnew[i]),
            .eq       (eq[i])
        );
    end

    always_comb
    begin
        wcnt_next = wcnt_reg;
        if (cfg_wr && cfg_idx == REG_PATTERN_LEN)
            wcnt_next = '0;   // held bytes are dropped when the length changes
        else if (accept)
        begin
            priority if (s_tlast || match)
                wcnt_next = '0;
            else if (full)
                wcnt_next = cnt_in;   // one byte left, the rest stays
            else
                wcnt_next = cnt_inc;
        end
    end

    // ---------------------------------------------------------------
    // results caused by the byte at the input
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] n_raw, n_eff;
    logic             marker;
    res_t             res [MAX_RES];

    always_comb
    begin
        priority if (match)
            n_raw = rlen;
        else if (s_tlast)
            n_raw = cnt_inc;     // flush the whole window
        else if (full)
            n_raw = CNT_W'(1);   // oldest byte only
        else
            n_raw = '0;
    end

    // a match deleted at the end of the string leaves only an empty end marker
    assign marker = s_tlast & (n_raw == '0);
    assign n_eff  = marker ? CNT_W'(1) : n_raw;

    for (genvar j = 0; j < MAX_RES; j++)
    begin : g_res
        byte_t rep_b, win_b;

        if (j < REPLACEMENT_MAX)
        begin : g_rep
            assign rep_b = rep_reg[8*j +: 8];
        end
        else
        begin : g_norep
            assign rep_b = '0;
        end

        if (j < PATTERN_MAX)
        begin : g_wb
            assign win_b = wnew[j % PATTERN_MAX];
        end
        else
        begin : g_nowb
            assign win_b = '0;
        end

        assign res[j].data = marker ? '0 : (match ? rep_b : win_b);
        assign res[j].has  = ~marker;
        assign res[j].last = s_tlast & (CNT_W'(j) == n_eff - CNT_W'(1));
    end

    // ---------------------------------------------------------------
    // output queue: a row of result cells, head in cell 0
    // ---------------------------------------------------------------
    logic [QCNT_W-1:0] qcnt_reg, qcnt_next;
    logic              pop, base_one;
    res_t              q [QDEPTH];

    assign m_tvalid = (qcnt_reg != '0);
    assign s_tready = (qcnt_reg <= QCNT_W'(1));
    assign pop      = m_tvalid & m_tready;
    // new results land behind a head that is not taken this cycle
    assign base_one = (qcnt_reg == QCNT_W'(1)) & ~pop;

    assign qcnt_next = qcnt_reg - QCNT_W'(pop) + (accept ? QCNT_W'(n_eff) : '0);

    for (genvar i = 0; i < QDEPTH; i++)
    begin : g_q
        out_ctl_t octl;
        res_t     lo_val, hi_val;
        logic     lo_ok, hi_ok;

        if (i < MAX_RES)
        begin : g_lo
            assign lo_val = res[i % MAX_RES];
            assign lo_ok  = (CNT_W'(i) < n_eff);
        end
        else
        begin : g_nolo
            assign lo_val = '0;
            assign lo_ok  = 1'b0;
        end

        if (i > 0)
        begin : g_hi
            assign hi_val = res[(i + MAX_RES - 1) % MAX_RES];
            assign hi_ok  = (CNT_W'(i - 1) < n_eff);
        end
        else
        begin : g_nohi
            assign hi_val = '0;
            assign hi_ok  = 1'b0;
        end

        assign octl.load  = accept & (base_one ? hi_ok : lo_ok);
        assign octl.shift = pop;

        ssr_out_cell u_cell (
            .clk      (clk),
            .ctl      (octl),
            .load_val (base_one ? hi_val : lo_val),
            .neigh    ((i < QDEPTH - 1) ? q[(i + 1) % QDEPTH] : '0),
            .q        (q[i])
        );
    end

    assign m_tdata = q[0].data;
    assign m_tuser = q[0].has;
    assign m_tlast = q[0].last;

    // ---------------------------------------------------------------
    // control state
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= LEN_W'(1);
            pat_reg  <= '0;
            rlen_reg <= '0;
            rep_reg  <= '0;
            wcnt_reg <= '0;
            qcnt_reg <= '0;
        end
        else
        begin
            plen_reg <= plen_next;
            pat_reg  <= pat_next;
            rlen_reg <= rlen_next;
            rep_reg  <= rep_next;
            wcnt_reg <= wcnt_next;
            qcnt_reg <= qcnt_next;
        end
    end

endmodule

`default_nettype wire

/* src/ssr_checker.sv */
`default_nettype none

module ssr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       s_tlast,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tuser,
    input wire logic       m_tlast
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output transfer withdrawn while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("output payload changed while stalled");

    // with nothing queued the block must take input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output queue");

    // the end of a string always yields at least one result
    a_last_yields: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no result after the last byte of a string");

    // an empty item only ever marks the end, with a zero byte
    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata == 8'd0))
        else $error("malformed end marker");

endmodule

bind stream_substring_replace ssr_checker u_ssr_checker (.*);

`default_nettype wire
